// ===== rtl/core/sha256_pkg.sv =====
// Package: SHA-256 constants, round functions and shared types.
package sha256_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic       OP_ABSORB = 1'b0;
  localparam logic       OP_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_LIMIT = 6'd55;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } wvars_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic wvars_t round_step(input wvars_t v, input word_t k, input word_t w);
    word_t t1;
    word_t t2;
    t1 = v.h + (rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25)) +
         ((v.e & v.f) ^ (~v.e & v.g)) + k + w;
    t2 = (rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22)) +
         ((v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c));
    round_step = '{a: t1 + t2, b: v.a, c: v.b, d: v.c,
                   e: v.d + t1, f: v.e, g: v.f, h: v.g};
  endfunction

endpackage

// ===== rtl/core/sha256_core.sv =====
// Compression engine: message memory, rolling schedule and one round per cycle.
module sha256_core
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic       start,
  input  logic       cv_reset,
  input  logic [2:0] cv_idx,
  output word_t      cv_word,
  output logic       done
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_FOLD = 3'b100
  } cstate_t;

  word_t   msg_mem [16];
  word_t   msg_q_r;
  word_t   sch_r [16];
  word_t   cv_r [8];
  wvars_t  v_r, v_nxt;
  cstate_t st_r, st_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [3:0] rd_addr;
  word_t   w_cur;

  assign done = (st_r == C_FOLD);
  assign cv_word = cv_r[cv_idx];
  assign rd_addr = (st_r == C_IDLE) ? 4'd0 : (rnd_r[3:0] + 4'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      msg_mem[wr_addr] <= wr_data;
    end
    msg_q_r <= msg_mem[rd_addr];
  end

  always_comb begin
    if (rnd_r < 7'd16) begin
      w_cur = msg_q_r;
    end else begin
      w_cur = ssig1(sch_r[14]) + sch_r[9] + ssig0(sch_r[1]) + sch_r[0];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    v_nxt   = v_r;
    case (st_r)
      C_IDLE: begin
        if (start) begin
          st_nxt  = C_RUN;
          rnd_nxt = 7'd0;
          v_nxt   = '{cv_r[0], cv_r[1], cv_r[2], cv_r[3],
                      cv_r[4], cv_r[5], cv_r[6], cv_r[7]};
        end
      end
      C_RUN: begin
        v_nxt   = round_step(v_r, RK[rnd_r[5:0]], w_cur);
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          st_nxt = C_FOLD;
        end
      end
      C_FOLD: st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= C_IDLE;
      rnd_r <= '0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
    end
    v_r <= v_nxt;
    if (st_r == C_RUN) begin
      for (int i = 0; i < 15; i++) begin
        sch_r[i] <= sch_r[i+1];
      end
      sch_r[15] <= w_cur;
    end
    if (!rst_n || cv_reset) begin
      for (int i = 0; i < 8; i++) begin
        cv_r[i] <= IV[i];
      end
    end else if (st_r == C_FOLD) begin
      cv_r[0] <= cv_r[0] + v_r.a;
      cv_r[1] <= cv_r[1] + v_r.b;
      cv_r[2] <= cv_r[2] + v_r.c;
      cv_r[3] <= cv_r[3] + v_r.d;
      cv_r[4] <= cv_r[4] + v_r.e;
      cv_r[5] <= cv_r[5] + v_r.f;
      cv_r[6] <= cv_r[6] + v_r.g;
      cv_r[7] <= cv_r[7] + v_r.h;
    end
  end

endmodule

// ===== rtl/core/sha256_stream_hasher.sv =====
// Top level: byte packing, padding sequencer and digest output.
//
//  channel | direction | tdata (low bit up)             | tuser
//  in_     | request   | opcode[0], data_byte[8:1]      | -
//  out_    | result    | digest_word[31:0], word_index[34:32] | -, tlast = last_word
//
//  The 64th byte of a block starts compression (64 rounds, one per cycle,
//  set by the single round unit, then a fold).
//  Finish writes 1 to 16 padding words, one per cycle, then compresses;
//  a second padded block, when needed, is written in full and compressed. Then 8 output words.
//  rst_n clears control and restores the initial hash value. out_tready low
//  holds the current word; input stays stalled until the digest is taken.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode, data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, word_index
  output logic        out_tlast
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COMP = 5'b00010,
    S_PADW = 5'b00100,
    S_PADC = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] cnt_r;
  logic [63:0] bits_r;
  logic [23:0] part_r;
  logic       two_r;     // an extra padded block precedes the length block
  logic       last_blk_r;
  logic [3:0] pw_r;      // padding word index
  logic [2:0] oidx_r;

  logic       wr_en;
  logic [3:0] wr_addr;
  word_t      wr_data;
  logic       start;
  logic       cv_reset;
  word_t      cv_word;
  logic       done;
  logic       acc;
  logic       op;
  logic [7:0] db;
  logic [63:0] total;
  logic [5:0] widx6;
  logic [23:0] part_al;

  assign op  = in_tdata[0];
  assign db  = in_tdata[8:1];
  assign in_tready = (st_r == S_IDLE);
  assign acc = in_tvalid && in_tready;
  assign total = bits_r + {55'd0, cnt_r, 3'd0};
  assign part_al = part_r << {2'd3 - cnt_r[1:0], 3'd0};

  sha256_core u_core (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_data, .start, .cv_reset,
    .cv_idx(oidx_r), .cv_word, .done
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[5:2];
    wr_data = {part_r, db};
    start   = 1'b0;
    widx6   = {pw_r, 2'b00};
    if (st_r == S_IDLE && acc && op == OP_ABSORB && cnt_r[1:0] == 2'd3) begin
      wr_en = 1'b1;
      start = (cnt_r == 6'd63);
    end
    if (st_r == S_PADW) begin
      wr_en   = 1'b1;
      wr_addr = pw_r;
      wr_data = '0;
      if (!last_blk_r || !two_r) begin
        for (int b = 0; b < 4; b++) begin
          if (widx6 + 6'(b) == cnt_r[5:0]) begin
            wr_data[31-8*b -: 8] = PAD_BYTE;
          end else if (widx6 + 6'(b) < cnt_r[5:0]) begin
            wr_data[31-8*b -: 8] = (b == 0) ? part_al[23:16] :
                                   (b == 1) ? part_al[15:8] : part_al[7:0];
          end
        end
      end
      if (!(two_r && !last_blk_r)) begin
        if (pw_r == 4'd14) wr_data = total[63:32];
        if (pw_r == 4'd15) wr_data = total[31:0];
      end
      start = (pw_r == 4'd15);
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc && op == OP_FINISH) st_nxt = S_PADW;
        else if (start) st_nxt = S_COMP;
      end
      S_COMP: if (done) st_nxt = S_IDLE;
      S_PADW: if (pw_r == 4'd15) st_nxt = S_PADC;
      S_PADC: if (done) st_nxt = (two_r && !last_blk_r) ? S_PADW : S_OUT;
      S_OUT:  if (out_tready && oidx_r == 3'd7) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign cv_reset = (st_r == S_OUT) && out_tready && (oidx_r == 3'd7);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {5'd0, oidx_r, cv_word};
  assign out_tlast = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cnt_r  <= '0;
      bits_r <= '0;
      pw_r   <= '0;
      oidx_r <= '0;
      two_r  <= 1'b0;
      last_blk_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE && acc) begin
        if (op == OP_ABSORB) begin
          part_r <= {part_r[15:0], db};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) bits_r <= bits_r + 64'd512;
        end else begin
          two_r      <= (cnt_r > LEN_LIMIT);
          last_blk_r <= 1'b0;
          pw_r       <= cnt_r[5:2];
        end
      end
      if (st_r == S_PADW) begin
        pw_r <= pw_r + 4'd1;
      end
      if (st_r == S_PADC && done) begin
        pw_r       <= '0;
        last_blk_r <= 1'b1;
      end
      if (st_r == S_OUT && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          cnt_r  <= '0;
          bits_r <= '0;
        end
      end
    end
  end

endmodule
